/* rtl/lns_pkg.sv */
// shared types, constants and helpers for the longest non-decreasing subsequence block
package lns_pkg;

  localparam int VALUES = 16;
  localparam int VAL_W  = 4;
  localparam int LEN_W  = 8;
  localparam int IDX_W  = (VALUES > 1) ? $clog2(VALUES) : 1;
  localparam int CMP_W  = ((VAL_W > IDX_W) ? VAL_W : IDX_W) + 1;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic valid;
    logic first;
    idx_t idx;
    len_t peak;
  } token_t;

  typedef struct packed {
    logic valid;
    len_t length_here;
    len_t length_best;
  } result_t;

  function automatic idx_t clamp_idx(input logic [VAL_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve >= CMP_W'(VALUES)) return IDX_W'(VALUES - 1);
    else return IDX_W'(ve);
  endfunction

  function automatic len_t sat_inc(input len_t l);
    if (l == LEN_MAX) return LEN_MAX;
    else return l + len_t'(1);
  endfunction

endpackage

/* rtl/lns_in_if.sv */
// input channel carrying one sequence element per item
interface lns_in_if;
  logic                          valid;
  logic                          ready;
  logic [lns_pkg::VAL_W-1:0]     value;
  logic                          first;

  modport source (output valid, output value, output first, input ready);
  modport sink   (input valid, input value, input first, output ready);
endinterface

/* rtl/lns_out_if.sv */
// output channel carrying the two lengths per item
interface lns_out_if;
  logic              valid;
  logic              ready;
  lns_pkg::len_t     length_here;
  lns_pkg::len_t     length_best;

  modport source (output valid, output length_here, output length_best, input ready);
  modport sink   (input valid, input length_here, input length_best, output ready);
endinterface

/* rtl/lns_cell.sv */
// one value cell: holds the best length ending at its value and passes the token on
module lns_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  lns_pkg::idx_t   pos,
  input  lns_pkg::token_t tok_in,
  output lns_pkg::token_t tok_out
);

  lns_pkg::len_t   entry;
  lns_pkg::len_t   entry_eff;
  lns_pkg::len_t   peak_max;
  lns_pkg::len_t   entry_next;
  lns_pkg::token_t tok_next;

  always_comb begin
    entry_eff  = tok_in.first ? '0 : entry;
    peak_max   = (entry_eff > tok_in.peak) ? entry_eff : tok_in.peak;
    tok_next   = tok_in;
    entry_next = entry_eff;
    if (pos < tok_in.idx) begin
      tok_next.peak = peak_max;
    end else if (pos == tok_in.idx) begin
      tok_next.peak = lns_pkg::sat_inc(peak_max);
      entry_next    = tok_next.peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry         <= '0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
      if (tok_in.valid) entry <= entry_next;
    end
  end

endmodule

/* rtl/lns_tail.sv */
// end of the chain: running maximum and output register
module lns_tail (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lns_pkg::token_t  tok_in,
  output lns_pkg::result_t res
);

  lns_pkg::len_t running_best;
  lns_pkg::len_t base;
  lns_pkg::len_t running_best_next;

  always_comb begin
    base              = tok_in.first ? '0 : running_best;
    running_best_next = (tok_in.peak > base) ? tok_in.peak : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_best <= '0;
      res.valid    <= 1'b0;
    end else if (advance) begin
      res.valid <= tok_in.valid;
      if (tok_in.valid) begin
        running_best    <= running_best_next;
        res.length_here <= tok_in.peak;
        res.length_best <= running_best_next;
      end
    end
  end

endmodule

/* rtl/longest_nondecreasing_subsequence.sv */
// Streaming longest non-decreasing subsequence length. Each item runs down a chain of
// VALUES cells, one cell per cycle, collecting the best length over the cells up to its
// value and writing its own length into the cell of its value; a tail stage keeps the
// running maximum. One item can be accepted every cycle while the output is not stalled:
// the item loads the first cell on the accepting edge, then moves through each remaining
// cell in turn and into the output register.
// A stalled output holds the whole chain. first clears the table as the item passes each
// cell; values of VALUES or more count as VALUES-1.
module longest_nondecreasing_subsequence (
  input  logic           clk,
  input  logic           rst,
  lns_in_if.sink         din,
  lns_out_if.source      dout
);

  lns_pkg::token_t  tok [0:lns_pkg::VALUES];
  lns_pkg::result_t res;
  logic             advance;

  assign advance = !res.valid || dout.ready;
  assign din.ready = advance;

  always_comb begin
    tok[0].valid = din.valid;
    tok[0].first = din.first;
    tok[0].idx   = lns_pkg::clamp_idx(din.value);
    tok[0].peak  = '0;
  end

  for (genvar i = 0; i < lns_pkg::VALUES; i++) begin : g_cell
    lns_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .pos     (lns_pkg::IDX_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  lns_tail u_tail (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tok_in  (tok[lns_pkg::VALUES]),
    .res     (res)
  );

  assign dout.valid       = res.valid;
  assign dout.length_here = res.length_here;
  assign dout.length_best = res.length_best;

endmodule

/* rtl/lns_checker.sv */
// port-level assertions for the top level, attached by bind
module lns_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lns_pkg::len_t length_here,
  input lns_pkg::len_t length_best
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(length_here) && $stable(length_best))
    else $error("stalled result changed");

  a_lengths: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length_here != '0 && length_best >= length_here)
    else $error("result lengths inconsistent");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind longest_nondecreasing_subsequence lns_checker u_lns_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .length_here (dout.length_here),
  .length_best (dout.length_best)
);

/* verif/lns_checker.sv */
// checker for the longest non-decreasing subsequence block: predicts and compares each result
module lns_scoreboard (
  input  logic clk,
  input  logic rst,
  lns_in_if    din,
  lns_out_if   dout,
  output int   mismatches,
  output int   outstanding,
  output int   results_seen
);

  typedef struct packed {
    lns_pkg::len_t here;
    lns_pkg::len_t best;
  } lengths_t;

  lns_pkg::len_t best_at [lns_pkg::VALUES];
  lns_pkg::len_t seq_best;
  lengths_t      expected_lengths [$];
  int            err_cnt = 0;
  int            seen_cnt = 0;

  task automatic report(input string msg);
    $display("[%0t] %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic lengths_t predict_lengths(input logic [lns_pkg::VAL_W-1:0] v,
                                               input logic f);
    lengths_t      calc;
    lns_pkg::len_t peak;
    int unsigned   slot;
    if (f) begin
      foreach (best_at[i]) best_at[i] = '0;
      seq_best = '0;
    end
    slot = (int'(v) >= lns_pkg::VALUES) ? lns_pkg::VALUES - 1 : int'(v);
    peak = '0;
    for (int i = 0; i <= int'(slot); i++) begin
      if (best_at[i] > peak) peak = best_at[i];
    end
    calc.here = (peak == lns_pkg::LEN_MAX) ? lns_pkg::LEN_MAX : peak + lns_pkg::len_t'(1);
    best_at[slot] = calc.here;
    if (calc.here > seq_best) seq_best = calc.here;
    calc.best = seq_best;
    return calc;
  endfunction

  always @(posedge clk) begin
    lengths_t want;
    lengths_t fresh;
    if (rst) begin
      foreach (best_at[i]) best_at[i] = '0;
      seq_best = '0;
      expected_lengths.delete();
    end else begin
      // older items leave first, so compare before taking a new one
      if (dout.valid && dout.ready) begin
        seen_cnt++;
        if (expected_lengths.size() == 0) begin
          report($sformatf("result %0d arrived with no item pending", seen_cnt));
        end else begin
          want = expected_lengths.pop_front();
          if (dout.length_here !== want.here)
            report($sformatf("result %0d: length_here %0d, expected %0d",
                             seen_cnt, dout.length_here, want.here));
          if (dout.length_best !== want.best)
            report($sformatf("result %0d: length_best %0d, expected %0d",
                             seen_cnt, dout.length_best, want.best));
        end
      end
      if (din.valid && din.ready) begin
        fresh = predict_lengths(din.value, din.first);
        expected_lengths = {expected_lengths, fresh};
      end
    end
    mismatches   <= err_cnt;
    outstanding  <= expected_lengths.size();
    results_seen <= seen_cnt;
  end

endmodule

/* verif/testbench.sv */
// top of the testbench: clock, reset, element stimulus under varying handshake pressure, verdict
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lns_in_if  din ();
  lns_out_if dout ();

  int fails;
  int pending;
  int checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int seq_count = 0;

  longest_nondecreasing_subsequence DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  lns_scoreboard lengths_check (
    .clk          (clk),
    .rst          (rst),
    .din          (din),
    .dout         (dout),
    .mismatches   (fails),
    .outstanding  (pending),
    .results_seen (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    dout.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_elem(input logic [lns_pkg::VAL_W-1:0] v, input logic f);
    if ($urandom_range(99) < idle_pct) begin
      din.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    din.valid <= 1'b1;
    din.value <= v;
    din.first <= f;
    do @(posedge clk); while (!din.ready);
    items_sent++;
    if (f) seq_count++;
  endtask

  task automatic wait_drained();
    din.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_sequence();
    int         kind;
    int         len;
    int         lo;
    int         hi;
    int         cur;
    logic [lns_pkg::VAL_W-1:0] v;
    logic       f;
    kind = $urandom_range(9);
    len  = $urandom_range(1, 40);
    lo   = $urandom_range(15);
    hi   = $urandom_range(lo, 15);
    cur  = lo;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0, 1, 2, 3: v = lns_pkg::VAL_W'($urandom_range(lo, hi));
        4, 5, 6: begin
          // mostly climbing with the odd jump
          if ($urandom_range(7) == 0) cur = $urandom_range(15);
          else cur = (cur + $urandom_range(0, 2) > 15) ? 15 : cur + $urandom_range(0, 2);
          v = lns_pkg::VAL_W'(cur);
        end
        8:       v = lns_pkg::VAL_W'(lo);
        default: v = lns_pkg::VAL_W'($urandom_range(15));
      endcase
      // kind 7 continues the previous sequence, kind 9 scatters first flags
      if (kind == 9) f = ($urandom_range(3) == 0);
      else f = (i == 0) && (kind != 7);
      send_elem(v, f);
    end
  endtask

  // long climb that drives the lengths into saturation
  task automatic saturating_run();
    logic [lns_pkg::VAL_W-1:0] v;
    send_elem(4'd0, 1'b1);
    for (int i = 1; i < 300; i++) begin
      if ($urandom_range(9) == 0) v = lns_pkg::VAL_W'($urandom_range(15));
      else v = lns_pkg::VAL_W'((i * 16) / 300);
      send_elem(v, 1'b0);
    end
  endtask

  initial begin
    int phase_start;
    din.valid  <= 1'b0;
    din.value  <= '0;
    din.first  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // no first flag after reset, then a continuation
    send_elem(4'd9, 1'b0);
    send_elem(4'd3, 1'b0);
    send_elem(4'd15, 1'b0);
    // repeated values extend the run
    send_elem(4'd15, 1'b1);
    send_elem(4'd0, 1'b0);
    send_elem(4'd0, 1'b0);
    send_elem(4'd15, 1'b0);
    send_elem(4'd8, 1'b0);
    send_elem(4'd8, 1'b0);
    send_elem(4'd8, 1'b0);
    // strictly decreasing
    send_elem(4'd15, 1'b1);
    send_elem(4'd12, 1'b0);
    send_elem(4'd7, 1'b0);
    send_elem(4'd3, 1'b0);
    send_elem(4'd0, 1'b0);
    // back-to-back first flags
    send_elem(4'd10, 1'b1);
    send_elem(4'd5, 1'b1);
    // rising from all zeros to all ones
    send_elem(4'd0, 1'b1);
    send_elem(4'd1, 1'b0);
    send_elem(4'd2, 1'b0);
    send_elem(4'd4, 1'b0);
    send_elem(4'd8, 1'b0);
    send_elem(4'd10, 1'b0);
    send_elem(4'd14, 1'b0);
    send_elem(4'd15, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 77; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 77; end
        default: begin idle_pct = 36; stall_pct <= 36; end
      endcase
      phase_start = items_sent;
      if (phase == 0) saturating_run();
      while (items_sent - phase_start < ((phase == 0) ? 530 : 245)) random_sequence();
      wait_drained();
    end

    repeat (lns_pkg::VALUES + 4) @(posedge clk);
    $display("sent %0d elements in %0d flagged sequences, %0d results checked", items_sent,
             seq_count, checked);
    $display("phases: directed, saturating climb, sender gaps, receiver stalls, both");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout: %0d results still pending", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/lns_pkg.sv
rtl/lns_in_if.sv
rtl/lns_out_if.sv
rtl/lns_cell.sv
rtl/lns_tail.sv
rtl/longest_nondecreasing_subsequence.sv
rtl/lns_checker.sv
verif/lns_checker.sv
verif/testbench.sv
